// File: rtl/core/matrix3x3_arith_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix arithmetic unit
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_ARITH_UNIT_DEFINES_SVH
`define MATRIX3X3_ARITH_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define M3AU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define M3AU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define M3AU_ASSERT(lbl, clk, rst_n, prop, msg)
`define M3AU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/m3au_pkg.sv
// ----------------------------------------------------------------------------
// m3au_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package m3au_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int DIM     = 3;
    localparam int NUM_EL  = DIM * DIM;
    localparam int IDX_W   = 4;
    localparam int RC_W    = 2;
    localparam int CMD_W   = 3;
    localparam int NUM_TMP = 3;
    localparam int TMP_W   = 2;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // request opcodes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 3'd0,
        CMD_LOAD_B = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_SUB    = 3'd3,
        CMD_MUL    = 3'd4,
        CMD_DET    = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELEM,
        S_MUL,
        S_DET,
        S_EMIT
    } t_state;

    // accumulator operations
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_AB_ADD,
        ACC_AB_SUB
    } t_acc_op;

    typedef enum logic {
        XS_A,
        XS_TMP
    } t_x_src;

    typedef enum logic {
        YS_A,
        YS_B
    } t_y_src;

    // controller -> datapath
    typedef struct packed {
        logic               wr_a;
        logic               wr_b;
        logic [IDX_W-1:0]   wr_idx;
        logic [IDX_W-1:0]   a_idx;
        logic [IDX_W-1:0]   b_idx;
        logic               x_ld;
        t_x_src             x_src;
        logic [TMP_W-1:0]   t_idx;
        logic               mul_en;
        t_y_src             y_src;
        t_acc_op            acc_op;
        logic               clr_ov;
        logic               save_en;
        logic [TMP_W-1:0]   save_idx;
        logic               emit;
        logic [RC_W-1:0]    row;
        logic [RC_W-1:0]    col;
        logic               last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/m3au_dpath.sv
// ----------------------------------------------------------------------------
// m3au_dpath
// Matrix storage, shared fixed-point multiplier, saturating accumulator and
// the output register.
// ----------------------------------------------------------------------------
`include "matrix3x3_arith_unit_defines.svh"

module m3au_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  m3au_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [m3au_pkg::DATA_W-1:0]  i_element_value,
    output m3au_pkg::t_dp_status                o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [m3au_pkg::RC_W-1:0]           o_out_row,
    output logic [m3au_pkg::RC_W-1:0]           o_out_col,
    output logic [m3au_pkg::DATA_W-1:0]         o_result_value,
    output logic                                o_overflow,
    output logic                                o_last
);

    logic signed [m3au_pkg::DATA_W-1:0] r_mat_a [m3au_pkg::NUM_EL];
    logic signed [m3au_pkg::DATA_W-1:0] r_mat_b [m3au_pkg::NUM_EL];
    logic signed [m3au_pkg::DATA_W-1:0] r_tmp   [m3au_pkg::NUM_TMP];
    logic signed [m3au_pkg::DATA_W-1:0] r_x;
    logic signed [m3au_pkg::PROD_W-1:0] r_prod;
    logic signed [m3au_pkg::DATA_W-1:0] r_acc;
    logic                               r_ov;

    logic                               r_out_valid;
    logic [m3au_pkg::RC_W-1:0]          r_out_row;
    logic [m3au_pkg::RC_W-1:0]          r_out_col;
    logic [m3au_pkg::DATA_W-1:0]        r_out_value;
    logic                               r_out_ov;
    logic                               r_out_last;

    logic signed [m3au_pkg::DATA_W-1:0] w_a_rd;
    logic signed [m3au_pkg::DATA_W-1:0] w_b_rd;
    logic signed [m3au_pkg::DATA_W-1:0] w_y;
    logic [m3au_pkg::DATA_W:0]          w_mul;
    logic [m3au_pkg::DATA_W:0]          w_res;
    logic                               w_res_ov;

    // clamp a one-bit-grown sum; result is {overflow, value}
    function automatic logic [m3au_pkg::DATA_W:0] sat_fit(
        input logic [m3au_pkg::DATA_W:0] s
    );
        if (s[m3au_pkg::DATA_W] != s[m3au_pkg::DATA_W-1]) begin
            return {1'b1, s[m3au_pkg::DATA_W] ? m3au_pkg::SAT_MIN : m3au_pkg::SAT_MAX};
        end
        return {1'b0, s[m3au_pkg::DATA_W-1:0]};
    endfunction

    function automatic logic [m3au_pkg::DATA_W:0] sat_add(
        input logic [m3au_pkg::DATA_W-1:0] a,
        input logic [m3au_pkg::DATA_W-1:0] b
    );
        return sat_fit({a[m3au_pkg::DATA_W-1], a} + {b[m3au_pkg::DATA_W-1], b});
    endfunction

    function automatic logic [m3au_pkg::DATA_W:0] sat_sub(
        input logic [m3au_pkg::DATA_W-1:0] a,
        input logic [m3au_pkg::DATA_W-1:0] b
    );
        return sat_fit({a[m3au_pkg::DATA_W-1], a} - {b[m3au_pkg::DATA_W-1], b});
    endfunction

    // drop fraction bits (floor) and clamp the product to the data width
    function automatic logic [m3au_pkg::DATA_W:0] mul_sat(
        input logic signed [m3au_pkg::PROD_W-1:0] p
    );
        logic signed [m3au_pkg::PROD_W-1:0] sh;
        logic                               fits;
        sh   = p >>> m3au_pkg::FRAC_W;
        fits = (&sh[m3au_pkg::PROD_W-1:m3au_pkg::DATA_W-1])
             | ~(|sh[m3au_pkg::PROD_W-1:m3au_pkg::DATA_W-1]);
        if (!fits) begin
            return {1'b1, sh[m3au_pkg::PROD_W-1] ? m3au_pkg::SAT_MIN : m3au_pkg::SAT_MAX};
        end
        return {1'b0, sh[m3au_pkg::DATA_W-1:0]};
    endfunction

    // single read port per matrix
    assign w_a_rd = r_mat_a[i_cmd.a_idx];
    assign w_b_rd = r_mat_b[i_cmd.b_idx];
    assign w_y    = (i_cmd.y_src == m3au_pkg::YS_A) ? w_a_rd : w_b_rd;

    // matrix element writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < m3au_pkg::NUM_EL; e++) begin
                r_mat_a[e] <= '0;
                r_mat_b[e] <= '0;
            end
        end else begin
            if (i_cmd.wr_a) begin
                r_mat_a[i_cmd.wr_idx] <= i_element_value;
            end
            if (i_cmd.wr_b) begin
                r_mat_b[i_cmd.wr_idx] <= i_element_value;
            end
        end
    end

    // operand latch, multiplier and cofactor scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_ld) begin
            r_x <= (i_cmd.x_src == m3au_pkg::XS_A) ? w_a_rd : r_tmp[i_cmd.t_idx];
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_x * w_y;
        end
        if (i_cmd.save_en) begin
            r_tmp[i_cmd.save_idx] <= r_acc;
        end
    end

    // saturating accumulator input
    always_comb begin
        w_mul = mul_sat(r_prod);
        case (i_cmd.acc_op)
            m3au_pkg::ACC_LOAD: begin
                w_res    = w_mul;
                w_res_ov = w_mul[m3au_pkg::DATA_W];
            end
            m3au_pkg::ACC_ADD: begin
                w_res    = sat_add(r_acc, w_mul[m3au_pkg::DATA_W-1:0]);
                w_res_ov = w_res[m3au_pkg::DATA_W] | w_mul[m3au_pkg::DATA_W];
            end
            m3au_pkg::ACC_SUB: begin
                w_res    = sat_sub(r_acc, w_mul[m3au_pkg::DATA_W-1:0]);
                w_res_ov = w_res[m3au_pkg::DATA_W] | w_mul[m3au_pkg::DATA_W];
            end
            m3au_pkg::ACC_AB_ADD: begin
                w_res    = sat_add(w_a_rd, w_b_rd);
                w_res_ov = w_res[m3au_pkg::DATA_W];
            end
            m3au_pkg::ACC_AB_SUB: begin
                w_res    = sat_sub(w_a_rd, w_b_rd);
                w_res_ov = w_res[m3au_pkg::DATA_W];
            end
            default: begin
                w_res    = '0;
                w_res_ov = 1'b0;
            end
        endcase
    end

    // accumulator with sticky overflow
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_op != m3au_pkg::ACC_NONE) begin
            r_acc <= w_res[m3au_pkg::DATA_W-1:0];
            r_ov  <= (r_ov & ~i_cmd.clr_ov) | w_res_ov;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row   <= i_cmd.row;
            r_out_col   <= i_cmd.col;
            r_out_value <= r_acc;
            r_out_ov    <= r_ov;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_result_value = r_out_value;
    assign o_overflow     = r_out_ov;
    assign o_last         = r_out_last;

    // checks
    `M3AU_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `M3AU_ASSERT(a_emit_lands, i_clk, i_rst_n, i_cmd.emit |=> r_out_valid, "emitted result not held")

endmodule

// File: rtl/core/m3au_ctrl.sv
// ----------------------------------------------------------------------------
// m3au_ctrl
// Request decode and step sequencer driving the matrix datapath.
// ----------------------------------------------------------------------------
`include "matrix3x3_arith_unit_defines.svh"

module m3au_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [m3au_pkg::CMD_W-1:0]      i_command,
    input  logic [m3au_pkg::RC_W-1:0]       i_row,
    input  logic [m3au_pkg::RC_W-1:0]       i_col,
    input  m3au_pkg::t_dp_status            i_sts,
    output m3au_pkg::t_dp_cmd               o_cmd
);

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0]           MUL_LAST = 5'd4;
    localparam logic [STEP_W-1:0]           DET_LAST = 5'd16;
    localparam logic [m3au_pkg::RC_W-1:0]   LAST_RC  = 2'(m3au_pkg::DIM - 1);

    m3au_pkg::t_state               r_state, n_state;
    m3au_pkg::t_cmd                 r_op, n_op;
    logic [STEP_W-1:0]              r_step, n_step;
    logic [m3au_pkg::RC_W-1:0]      r_row, n_row;
    logic [m3au_pkg::RC_W-1:0]      r_col, n_col;
    logic                           w_last;

    // row-major element index
    function automatic logic [m3au_pkg::IDX_W-1:0] elem_idx(
        input logic [m3au_pkg::RC_W-1:0] row,
        input logic [m3au_pkg::RC_W-1:0] col
    );
        return ({2'b00, row} << 1) + {2'b00, row} + {2'b00, col};
    endfunction

    assign w_last = (r_op == m3au_pkg::CMD_DET) || (r_row == LAST_RC && r_col == LAST_RC);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m3au_pkg::S_IDLE;
            r_op    <= m3au_pkg::CMD_LOAD_A;
            r_step  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_step  = r_step;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            m3au_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_step = '0;
                    n_row  = '0;
                    n_col  = '0;
                    case (m3au_pkg::t_cmd'(i_command))
                        m3au_pkg::CMD_ADD, m3au_pkg::CMD_SUB: begin
                            n_op    = m3au_pkg::t_cmd'(i_command);
                            n_state = m3au_pkg::S_ELEM;
                        end
                        m3au_pkg::CMD_MUL: begin
                            n_op    = m3au_pkg::CMD_MUL;
                            n_state = m3au_pkg::S_MUL;
                        end
                        m3au_pkg::CMD_DET: begin
                            n_op    = m3au_pkg::CMD_DET;
                            n_state = m3au_pkg::S_DET;
                        end
                        default: n_state = m3au_pkg::S_IDLE;
                    endcase
                end
            end
            m3au_pkg::S_ELEM: n_state = m3au_pkg::S_EMIT;
            m3au_pkg::S_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = m3au_pkg::S_EMIT;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            m3au_pkg::S_DET: begin
                if (r_step == DET_LAST) begin
                    n_state = m3au_pkg::S_EMIT;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            m3au_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    if (w_last) begin
                        n_state = m3au_pkg::S_IDLE;
                    end else begin
                        n_step = '0;
                        if (r_col == LAST_RC) begin
                            n_col = '0;
                            n_row = r_row + 2'd1;
                        end else begin
                            n_col = r_col + 2'd1;
                        end
                        n_state = (r_op == m3au_pkg::CMD_MUL) ? m3au_pkg::S_MUL
                                                              : m3au_pkg::S_ELEM;
                    end
                end
            end
            default: n_state = m3au_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            m3au_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.wr_idx = elem_idx(i_row, i_col);
                if (i_in_valid && i_row <= LAST_RC && i_col <= LAST_RC) begin
                    o_cmd.wr_a = (m3au_pkg::t_cmd'(i_command) == m3au_pkg::CMD_LOAD_A);
                    o_cmd.wr_b = (m3au_pkg::t_cmd'(i_command) == m3au_pkg::CMD_LOAD_B);
                end
            end
            m3au_pkg::S_ELEM: begin
                o_cmd.a_idx  = elem_idx(r_row, r_col);
                o_cmd.b_idx  = elem_idx(r_row, r_col);
                o_cmd.acc_op = (r_op == m3au_pkg::CMD_SUB) ? m3au_pkg::ACC_AB_SUB
                                                          : m3au_pkg::ACC_AB_ADD;
                o_cmd.clr_ov = 1'b1;
            end
            // sum of A[row][k] * B[k][col], k = 0..2
            m3au_pkg::S_MUL: begin
                o_cmd.y_src = m3au_pkg::YS_B;
                o_cmd.x_src = m3au_pkg::XS_A;
                case (r_step)
                    5'd0: begin
                        o_cmd.x_ld  = 1'b1;
                        o_cmd.a_idx = elem_idx(r_row, 2'd0);
                    end
                    5'd1: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.b_idx  = elem_idx(2'd0, r_col);
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.a_idx  = elem_idx(r_row, 2'd1);
                    end
                    5'd2: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.b_idx  = elem_idx(2'd1, r_col);
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.a_idx  = elem_idx(r_row, 2'd2);
                        o_cmd.acc_op = m3au_pkg::ACC_LOAD;
                        o_cmd.clr_ov = 1'b1;
                    end
                    5'd3: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.b_idx  = elem_idx(2'd2, r_col);
                        o_cmd.acc_op = m3au_pkg::ACC_ADD;
                    end
                    5'd4: o_cmd.acc_op = m3au_pkg::ACC_ADD;
                    default: o_cmd.acc_op = m3au_pkg::ACC_NONE;
                endcase
            end
            // three cofactors into scratch, then the first-row expansion
            m3au_pkg::S_DET: begin
                o_cmd.y_src = m3au_pkg::YS_A;
                case (r_step)
                    5'd0: begin
                        o_cmd.x_ld  = 1'b1;
                        o_cmd.a_idx = 4'd4;
                    end
                    5'd1: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd8;
                    end
                    5'd2: begin
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.a_idx  = 4'd7;
                        o_cmd.acc_op = m3au_pkg::ACC_LOAD;
                        o_cmd.clr_ov = 1'b1;
                    end
                    5'd3: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd5;
                    end
                    5'd4: begin
                        o_cmd.acc_op = m3au_pkg::ACC_SUB;
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.a_idx  = 4'd3;
                    end
                    5'd5: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd8;
                    end
                    5'd6: begin
                        o_cmd.x_ld     = 1'b1;
                        o_cmd.a_idx    = 4'd5;
                        o_cmd.acc_op   = m3au_pkg::ACC_LOAD;
                        o_cmd.save_en  = 1'b1;
                        o_cmd.save_idx = 2'd0;
                    end
                    5'd7: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd6;
                    end
                    5'd8: begin
                        o_cmd.acc_op = m3au_pkg::ACC_SUB;
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.a_idx  = 4'd3;
                    end
                    5'd9: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd7;
                    end
                    5'd10: begin
                        o_cmd.x_ld     = 1'b1;
                        o_cmd.a_idx    = 4'd4;
                        o_cmd.acc_op   = m3au_pkg::ACC_LOAD;
                        o_cmd.save_en  = 1'b1;
                        o_cmd.save_idx = 2'd1;
                    end
                    5'd11: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd6;
                    end
                    5'd12: begin
                        o_cmd.acc_op = m3au_pkg::ACC_SUB;
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.x_src  = m3au_pkg::XS_TMP;
                        o_cmd.t_idx  = 2'd0;
                    end
                    5'd13: begin
                        o_cmd.mul_en   = 1'b1;
                        o_cmd.a_idx    = 4'd0;
                        o_cmd.save_en  = 1'b1;
                        o_cmd.save_idx = 2'd2;
                        o_cmd.x_ld     = 1'b1;
                        o_cmd.x_src    = m3au_pkg::XS_TMP;
                        o_cmd.t_idx    = 2'd1;
                    end
                    5'd14: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd1;
                        o_cmd.acc_op = m3au_pkg::ACC_LOAD;
                        o_cmd.x_ld   = 1'b1;
                        o_cmd.x_src  = m3au_pkg::XS_TMP;
                        o_cmd.t_idx  = 2'd2;
                    end
                    5'd15: begin
                        o_cmd.mul_en = 1'b1;
                        o_cmd.a_idx  = 4'd2;
                        o_cmd.acc_op = m3au_pkg::ACC_SUB;
                    end
                    5'd16: o_cmd.acc_op = m3au_pkg::ACC_ADD;
                    default: o_cmd.acc_op = m3au_pkg::ACC_NONE;
                endcase
            end
            m3au_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.row  = (r_op == m3au_pkg::CMD_DET) ? 2'd0 : r_row;
                o_cmd.col  = (r_op == m3au_pkg::CMD_DET) ? 2'd0 : r_col;
                o_cmd.last = w_last;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // checks
    `M3AU_ASSERT(a_emit_free, i_clk, i_rst_n, o_cmd.emit |-> i_sts.out_free, "emit into full output")
    `M3AU_ASSERT(a_last_idle, i_clk, i_rst_n, (o_cmd.emit && o_cmd.last) |=> (r_state == m3au_pkg::S_IDLE), "no return to idle after last")
    `M3AU_ASSERT(a_stall_hold, i_clk, i_rst_n, (r_state == m3au_pkg::S_EMIT && !i_sts.out_free) |=> (r_state == m3au_pkg::S_EMIT), "left emit while stalled")

endmodule

// File: rtl/core/matrix3x3_arith_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_arith_unit
// 3x3 signed Q16.16 matrix add / subtract / multiply and determinant of A.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                   tuser        tlast
// s_axis    in   row[1:0] col[3:2] value[35:4] pad    command[2:0] -
// m_axis    out  row[1:0] col[3:2] value[35:4] pad    overflow[0]  last
//
// Loads are accepted back to back while idle. Add/subtract emit each element
// after its sequencer step; multiply: five steps of the sequencer plus emit
// per element (one 32x32 multiplier); determinant: its steps are bounded by
// the single read port on matrix A. Output stalls hold the sequencer in its
// emit step. Reset clears both matrices and the output valid.
// ----------------------------------------------------------------------------
module matrix3x3_arith_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index, col_index, element_value, zero pad
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row, out_col, result_value, zero pad
    output logic [0:0]  m_axis_tuser,   // overflow
    output logic        m_axis_tlast
);

    m3au_pkg::t_dp_cmd                  w_cmd;
    m3au_pkg::t_dp_status               w_sts;
    logic [m3au_pkg::RC_W-1:0]          w_out_row;
    logic [m3au_pkg::RC_W-1:0]          w_out_col;
    logic [m3au_pkg::DATA_W-1:0]        w_out_value;
    logic                               w_out_ov;

    // sequencer
    m3au_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_command  (s_axis_tuser),
        .i_row      (s_axis_tdata[1:0]),
        .i_col      (s_axis_tdata[3:2]),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    m3au_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_element_value (s_axis_tdata[35:4]),
        .o_sts           (w_sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_row       (w_out_row),
        .o_out_col       (w_out_col),
        .o_result_value  (w_out_value),
        .o_overflow      (w_out_ov),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_out_value, w_out_col, w_out_row};
    assign m_axis_tuser = w_out_ov;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 Q16.16 matrix unit. Requests are driven on
// the slave stream with random gaps. The bench predicts load, add, subtract,
// multiply and determinant from its own copy of both matrices. Every result
// on the master stream is compared field by field, with random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 7;
    localparam int  RANDOM_ITEMS  = 470;
    localparam int  IDLE_PCT      = 36;
    localparam int  DRAIN_CYCLES  = 60;
    localparam int  CYCLE_LIMIT   = 400000;

    // codes the block leaves unused
    localparam logic [m3au_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [m3au_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam logic [m3au_pkg::DATA_W-1:0] Q_ONE       = 32'h0001_0000;
    localparam logic [m3au_pkg::DATA_W-1:0] Q_MINUS_1P5 = 32'hFFFE_8000;
    localparam logic [m3au_pkg::DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483647 - 64'sd1;

    typedef struct packed {
        logic [m3au_pkg::RC_W-1:0]   row;
        logic [m3au_pkg::RC_W-1:0]   col;
        logic [m3au_pkg::DATA_W-1:0] value;
        logic                        ovf;
        logic                        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // row[1:0], col[3:2], value[35:4], zero pad
    logic [2:0]  s_axis_tuser = '0;   // command[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // row[1:0], col[3:2], value[35:4], zero pad
    logic [0:0]  m_axis_tuser;        // overflow[0]
    logic        m_axis_tlast;

    // predictor state
    longint  mat_a [m3au_pkg::NUM_EL];
    longint  mat_b [m3au_pkg::NUM_EL];
    bit      sat_seen;
    t_result result_q [$];

    bit tx_throttle = 1'b1;
    bit rx_throttle = 1'b1;
    int fail_count  = 0;
    int cycle_count = 0;

    matrix3x3_arith_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed-point arithmetic, saturating to the data word
    // ------------------------------------------------------------------
    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            sat_seen = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            sat_seen = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // operands are in word range, so the exact product fits 64 bits;
    // the arithmetic shift rounds toward minus infinity
    function automatic longint q_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp_word(p >>> m3au_pkg::FRAC_W);
    endfunction

    // ------------------------------------------------------------------
    // apply one accepted request to the model, queue its results
    // ------------------------------------------------------------------
    function automatic void predict_request(input logic [m3au_pkg::CMD_W-1:0] cmd,
                                            input logic [m3au_pkg::RC_W-1:0] row,
                                            input logic [m3au_pkg::RC_W-1:0] col,
                                            input logic [m3au_pkg::DATA_W-1:0] value);
        longint  acc;
        longint  c0;
        longint  c1;
        longint  c2;
        int      idx;
        t_result res;
        case (cmd)
            m3au_pkg::CMD_LOAD_A, m3au_pkg::CMD_LOAD_B: begin
                // index 3 writes nothing
                if (row < m3au_pkg::DIM && col < m3au_pkg::DIM) begin
                    idx = row * m3au_pkg::DIM + col;
                    if (cmd == m3au_pkg::CMD_LOAD_A) mat_a[idx] = longint'($signed(value));
                    else mat_b[idx] = longint'($signed(value));
                end
            end
            m3au_pkg::CMD_ADD, m3au_pkg::CMD_SUB, m3au_pkg::CMD_MUL: begin
                for (int i = 0; i < m3au_pkg::DIM; i++) begin
                    for (int j = 0; j < m3au_pkg::DIM; j++) begin
                        idx = i * m3au_pkg::DIM + j;
                        sat_seen = 1'b0;
                        if (cmd == m3au_pkg::CMD_ADD) begin
                            acc = clamp_word(mat_a[idx] + mat_b[idx]);
                        end else if (cmd == m3au_pkg::CMD_SUB) begin
                            acc = clamp_word(mat_a[idx] - mat_b[idx]);
                        end else begin
                            acc = q_mul(mat_a[i*m3au_pkg::DIM], mat_b[j]);
                            for (int k = 1; k < m3au_pkg::DIM; k++)
                                acc = clamp_word(acc + q_mul(mat_a[i*m3au_pkg::DIM+k],
                                                             mat_b[k*m3au_pkg::DIM+j]));
                        end
                        res.row   = 2'(i);
                        res.col   = 2'(j);
                        res.value = acc[m3au_pkg::DATA_W-1:0];
                        res.ovf   = sat_seen;
                        res.last  = (idx == m3au_pkg::NUM_EL - 1);
                        result_q.push_back(res);
                    end
                end
            end
            m3au_pkg::CMD_DET: begin
                // cofactor expansion along the first row, innermost first
                sat_seen = 1'b0;
                c0  = clamp_word(q_mul(mat_a[4], mat_a[8]) - q_mul(mat_a[7], mat_a[5]));
                c1  = clamp_word(q_mul(mat_a[3], mat_a[8]) - q_mul(mat_a[5], mat_a[6]));
                c2  = clamp_word(q_mul(mat_a[3], mat_a[7]) - q_mul(mat_a[4], mat_a[6]));
                acc = clamp_word(q_mul(mat_a[0], c0) - q_mul(mat_a[1], c1));
                acc = clamp_word(acc + q_mul(mat_a[2], c2));
                res.row   = '0;
                res.col   = '0;
                res.value = acc[m3au_pkg::DATA_W-1:0];
                res.ovf   = sat_seen;
                res.last  = 1'b1;
                result_q.push_back(res);
            end
            default: ;  // unused codes are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // send one request; entered and left on a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(input logic [m3au_pkg::CMD_W-1:0] cmd,
                                input logic [m3au_pkg::RC_W-1:0] row,
                                input logic [m3au_pkg::RC_W-1:0] col,
                                input logic [m3au_pkg::DATA_W-1:0] value);
        while (tx_throttle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, value, col, row};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(cmd, row, col, value);
        @(negedge i_clk);
    endtask

    function automatic logic [m3au_pkg::DATA_W-1:0] rand_element();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0010_0000) - 32'h0008_0000;  // within +/-8.0
            1: return $urandom_range(32'h0200_0000) - 32'h0100_0000;  // within +/-256.0
            2: return $urandom();
            default: begin
                case ($urandom_range(5))
                    0: return m3au_pkg::SAT_MAX;
                    1: return m3au_pkg::SAT_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    4: return ALL_ONES;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result: row %0d col %0d value %h",
                       m_axis_tdata[1:0], m_axis_tdata[3:2], m_axis_tdata[35:4]);
                fail_count++;
            end else begin
                exp_res = result_q.pop_front();
                if (m_axis_tdata[1:0] !== exp_res.row) begin
                    $error("out_row: expected %0d, got %0d", exp_res.row, m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[3:2] !== exp_res.col) begin
                    $error("out_col: expected %0d, got %0d", exp_res.col, m_axis_tdata[3:2]);
                    fail_count++;
                end
                if (m_axis_tdata[35:4] !== exp_res.value) begin
                    $error("result_value: expected %h, got %h",
                           exp_res.value, m_axis_tdata[35:4]);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== exp_res.ovf) begin
                    $error("overflow: expected %0b, got %0b", exp_res.ovf, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_res.last) begin
                    $error("last: expected %0b, got %0b", exp_res.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (rx_throttle) m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        else m_axis_tready <= 1'b1;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // both matrices must read back as zero after reset
    task automatic test_reset_state();
        send_request(m3au_pkg::CMD_ADD, 2'd0, 2'd0, '0);
        send_request(m3au_pkg::CMD_MUL, 2'd0, 2'd0, '0);
        send_request(m3au_pkg::CMD_DET, 2'd0, 2'd0, '0);
    endtask

    // element-wise add and subtract, saturating both ways
    task automatic test_elementwise();
        send_request(m3au_pkg::CMD_LOAD_A, 2'd0, 2'd0, m3au_pkg::SAT_MAX);
        send_request(m3au_pkg::CMD_LOAD_A, 2'd0, 2'd1, m3au_pkg::SAT_MIN);
        send_request(m3au_pkg::CMD_LOAD_A, 2'd2, 2'd2, ALL_ONES);
        send_request(m3au_pkg::CMD_LOAD_B, 2'd0, 2'd0, Q_ONE);
        send_request(m3au_pkg::CMD_LOAD_B, 2'd0, 2'd1, Q_ONE);
        send_request(m3au_pkg::CMD_LOAD_B, 2'd2, 2'd2, m3au_pkg::SAT_MIN);
        send_request(m3au_pkg::CMD_ADD, 2'd3, 2'd3, ALL_ONES);
        send_request(m3au_pkg::CMD_SUB, 2'd1, 2'd2, '0);
    endtask

    // out-of-range loads and unused codes must leave the matrices alone
    task automatic test_ignored_requests();
        send_request(m3au_pkg::CMD_LOAD_A, 2'd3, 2'd1, m3au_pkg::SAT_MAX);
        send_request(m3au_pkg::CMD_LOAD_B, 2'd2, 2'd3, m3au_pkg::SAT_MAX);
        send_request(CMD_RSVD6, 2'd0, 2'd0, '0);
        send_request(CMD_RSVD7, 2'd3, 2'd3, ALL_ONES);
        send_request(m3au_pkg::CMD_ADD, 2'd0, 2'd0, '0);
    endtask

    // product, including rounding of a negative product toward minus infinity
    task automatic test_multiply();
        send_request(m3au_pkg::CMD_LOAD_A, 2'd1, 2'd1, Q_MINUS_1P5);
        send_request(m3au_pkg::CMD_LOAD_B, 2'd1, 2'd1, 32'h0000_0003);
        send_request(m3au_pkg::CMD_MUL, 2'd0, 2'd0, '0);
    endtask

    // determinant with extreme entries, then with a tamer leading term
    task automatic test_determinant();
        send_request(m3au_pkg::CMD_DET, 2'd0, 2'd0, '0);
        send_request(m3au_pkg::CMD_LOAD_A, 2'd0, 2'd0, Q_ONE);
        send_request(m3au_pkg::CMD_DET, 2'd2, 2'd1, ALL_ONES);
    endtask

    // mostly load bursts closed by a compute request, with some noise
    task automatic test_random_sequences();
        int                         accepted;
        int                         n_loads;
        logic [m3au_pkg::CMD_W-1:0] cmd;
        logic [m3au_pkg::RC_W-1:0]  row;
        logic [m3au_pkg::RC_W-1:0]  col;
        accepted = 0;
        while (accepted < RANDOM_ITEMS) begin
            // a stretch with no idling on either side
            tx_throttle = !(accepted >= 150 && accepted < 250);
            rx_throttle = tx_throttle;
            if ($urandom_range(99) < 80) begin
                n_loads = $urandom_range(9, 1);
                repeat (n_loads) begin
                    cmd = $urandom_range(1) ? m3au_pkg::CMD_LOAD_B : m3au_pkg::CMD_LOAD_A;
                    send_request(cmd, 2'($urandom_range(2)), 2'($urandom_range(2)),
                                 rand_element());
                end
                cmd = 3'($urandom_range(int'(m3au_pkg::CMD_DET), int'(m3au_pkg::CMD_ADD)));
                send_request(cmd, 2'($urandom_range(3)), 2'($urandom_range(3)), $urandom());
                accepted += n_loads + 1;
            end else begin
                cmd = 3'($urandom_range(7));
                row = 2'($urandom_range(3));
                col = 2'($urandom_range(3));
                send_request(cmd, row, col, $urandom());
                if (cmd == m3au_pkg::CMD_ADD || cmd == m3au_pkg::CMD_SUB
                    || cmd == m3au_pkg::CMD_MUL || cmd == m3au_pkg::CMD_DET
                    || ((cmd == m3au_pkg::CMD_LOAD_A || cmd == m3au_pkg::CMD_LOAD_B)
                        && row != 2'd3 && col != 2'd3))
                    accepted++;
            end
        end
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int n = 0; n < m3au_pkg::NUM_EL; n++) begin
            mat_a[n] = 0;
            mat_b[n] = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_elementwise();
        test_ignored_requests();
        test_multiply();
        test_determinant();
        test_random_sequences();

        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/m3au_pkg.sv
rtl/core/m3au_dpath.sv
rtl/core/m3au_ctrl.sv
rtl/core/matrix3x3_arith_unit.sv
tb/tb_top.sv
